// ===== rtl/annealed_random_param_search_defines.svh =====
// Assertion macros shared by the parameter search RTL.
// Included by the top level only; no other dependencies.
`ifndef ANNEALED_RANDOM_PARAM_SEARCH_DEFINES_SVH
`define ANNEALED_RANDOM_PARAM_SEARCH_DEFINES_SVH
// Implication check on the rising clock, muted in reset.
`define ARPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check on the rising clock, muted in reset.
`define ARPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/arps_pkg.sv =====
// Package for the annealed random parameter search: types, constants, codes.
// No dependencies.
`timescale 1ns / 1ps
package arps_pkg;
    localparam int unsigned MaxParamsDefault = 16;
    localparam logic signed [31:0] LimitLow  = -32'sd65536000;
    localparam logic signed [31:0] LimitHigh = 32'sd65536000;
    localparam logic [16:0] TempOne = 17'd65536;
    localparam logic [4:0]  CountReset = 5'd16;
    localparam logic [15:0] DecayReset = 16'd58982;
    localparam logic [16:0] FloorReset = 17'd66;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_REPORT  = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CFG_COUNT = 2'd0,
        CFG_DECAY = 2'd1,
        CFG_FLOOR = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PICK,
        ST_FETCH,
        ST_RADIUS_MUL,
        ST_ENDS,
        ST_SPAN_MUL,
        ST_WRITE,
        ST_TEMP_MUL,
        ST_TEMP_CLAMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [31:0] param_value;
        logic signed [31:0] test_value;
        logic signed [31:0] best_fitness_out;
        logic               improved;
        logic [3:0]         mutated_index;
        logic [16:0]        temperature_out;
    } t_result;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         index;
        logic signed [31:0] value;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [31:0] fitness;
        logic [15:0]        rand_pick;
        logic [15:0]        rand_fraction;
    } t_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [16:0] data;
    } t_cfg;
endpackage

// ===== rtl/arps_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on arps_pkg.
`timescale 1ns / 1ps
interface arps_item_if;
    logic valid;
    logic ready;
    arps_pkg::t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface arps_result_if;
    logic valid;
    logic ready;
    arps_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface arps_cfg_if;
    logic valid;
    logic ready;
    arps_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/annealed_random_param_search.sv =====
// Top level of the annealed random parameter search: table, sequencer, one multiplier.
// Depends on arps_pkg, arps_if.sv and annealed_random_param_search_defines.svh.
//
//  channel   | direction | carries
//  i_item    | in        | action, index, value, limits, fitness, random values
//  o_result  | out       | read values, best fitness, improved, mutated index, temperature
//  i_cfg     | in        | register index, write data
//
// Load and read go straight to the result; restart sweeps every entry in use; a
// fitness report sweeps every entry in use, then makes four uses of the shared
// multiplier with fetch, clamp and write steps; with no entry in use, just the temperature.
// The block takes no item until its result is taken.
// Reset is synchronous; the table returns to its reset values at once.
`timescale 1ns / 1ps
`include "annealed_random_param_search_defines.svh"
module annealed_random_param_search #(
    parameter int unsigned MAX_PARAMS = arps_pkg::MaxParamsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    arps_item_if.sink     i_item,
    arps_result_if.source o_result,
    arps_cfg_if.sink      i_cfg
);
    import arps_pkg::*;

    localparam int unsigned IdxW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int unsigned CntW = $clog2(MAX_PARAMS + 1);

    // table storage
    logic signed [31:0] r_best  [MAX_PARAMS];
    logic signed [31:0] r_trial [MAX_PARAMS];
    logic signed [31:0] r_lower [MAX_PARAMS];
    logic signed [31:0] r_upper [MAX_PARAMS];
    logic signed [31:0] r_score;
    logic [16:0] r_temp;
    logic [4:0]  r_count;
    logic [15:0] r_decay;
    logic [16:0] r_floor;

    t_state r_state, n_state;
    t_item  r_item;
    logic [IdxW-1:0] r_ptr;
    logic [IdxW-1:0] r_k;
    logic r_improved;
    logic r_mutated;
    logic signed [33:0] r_lo;
    logic signed [33:0] r_hi;
    logic signed [33:0] r_cur;
    logic signed [65:0] r_prod;
    t_result r_res;
    logic r_out_valid;

    // entries in use, limited to the table depth
    logic [CntW-1:0] w_n;
    always_comb begin
        if ({27'd0, r_count} > 32'(MAX_PARAMS)) begin
            w_n = CntW'(MAX_PARAMS);
        end else begin
            w_n = CntW'(r_count);
        end
    end

    // shared multiplier operands, chosen by state
    logic signed [33:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [65:0] w_mul;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_PICK: begin
                w_ma = 34'($unsigned(r_item.rand_pick));
                w_mb = 32'(w_n);
            end
            ST_RADIUS_MUL: begin
                w_ma = r_hi - r_lo;
                w_mb = 32'(r_temp);
            end
            ST_SPAN_MUL: begin
                w_ma = r_hi - r_lo;
                w_mb = 32'($unsigned(r_item.rand_fraction));
            end
            ST_TEMP_MUL: begin
                w_ma = 34'(r_temp);
                w_mb = 32'(r_decay);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_mul = 66'(w_ma) * 66'(w_mb);
    end

    // floor of product over 65536 (arithmetic shift floors)
    logic signed [49:0] w_shr;
    assign w_shr = 50'(r_prod >>> 16);

    logic signed [33:0] w_rad;
    assign w_rad = 34'(w_shr);

    // clamp both interval ends, lower limit first
    logic signed [33:0] w_dn, w_up, w_lo_c, w_hi_c;
    always_comb begin
        w_dn = r_cur - w_rad;
        w_up = r_cur + w_rad;
        if (w_dn < r_lo) begin
            w_lo_c = r_lo;
        end else if (w_dn > r_hi) begin
            w_lo_c = r_hi;
        end else begin
            w_lo_c = w_dn;
        end
        if (w_up < r_lo) begin
            w_hi_c = r_lo;
        end else if (w_up > r_hi) begin
            w_hi_c = r_hi;
        end else begin
            w_hi_c = w_up;
        end
    end

    logic [16:0] w_flo;
    assign w_flo = (r_floor > TempOne) ? TempOne : r_floor;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_state = ST_DONE;
                    if (i_item.data.action == ACT_REPORT || i_item.data.action == ACT_RESTART) begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (w_n == '0 || {1'b0, r_ptr} == (IdxW+1)'(w_n - 1'b1)) begin
                    if (r_item.action == ACT_RESTART) begin
                        n_state = ST_DONE;
                    end else if (w_n == '0) begin
                        n_state = ST_TEMP_MUL;
                    end else begin
                        n_state = ST_PICK;
                    end
                end
            end
            ST_PICK:       n_state = ST_FETCH;
            ST_FETCH:      n_state = ST_RADIUS_MUL;
            ST_RADIUS_MUL: n_state = ST_ENDS;
            ST_ENDS:       n_state = ST_SPAN_MUL;
            ST_SPAN_MUL:   n_state = ST_WRITE;
            ST_WRITE:      n_state = ST_TEMP_MUL;
            ST_TEMP_MUL:   n_state = ST_TEMP_CLAMP;
            ST_TEMP_CLAMP: n_state = ST_DONE;
            ST_DONE: begin
                if (o_result.ready && r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_item.ready  = (r_state == ST_IDLE);
        i_cfg.ready   = (r_state == ST_IDLE);
        o_result.valid = r_out_valid;
        o_result.data  = r_res;
    end

    logic w_hit;
    logic signed [31:0] w_fit_ok;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count <= CountReset;
            r_decay <= DecayReset;
            r_floor <= FloorReset;
            r_score <= 32'sh8000_0000;
            r_temp  <= TempOne;
            for (int i = 0; i < int'(MAX_PARAMS); i++) begin
                r_best[i]  <= '0;
                r_trial[i] <= '0;
                r_lower[i] <= LimitLow;
                r_upper[i] <= LimitHigh;
            end
        end else begin
            r_state <= n_state;
            // configuration writes while idle
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.data.index)
                    CFG_COUNT: r_count <= i_cfg.data.data[4:0];
                    CFG_DECAY: r_decay <= i_cfg.data.data[15:0];
                    CFG_FLOOR: r_floor <= i_cfg.data.data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_item <= i_item.data;
                        r_ptr  <= '0;
                        r_mutated  <= 1'b0;
                        r_res.improved      <= 1'b0;
                        r_res.mutated_index <= '0;
                        if (i_item.data.action == ACT_REPORT &&
                            i_item.data.fitness >= r_score) begin
                            r_score <= i_item.data.fitness;
                            r_improved <= 1'b1;
                        end else begin
                            r_improved <= 1'b0;
                        end
                        if ({1'b0, i_item.data.index} < 5'(w_n) &&
                            i_item.data.action == ACT_LOAD) begin
                            r_best[IdxW'(i_item.data.index)]  <= i_item.data.value;
                            r_trial[IdxW'(i_item.data.index)] <= i_item.data.value;
                            r_lower[IdxW'(i_item.data.index)] <= i_item.data.min_value;
                            r_upper[IdxW'(i_item.data.index)] <= i_item.data.max_value;
                        end
                        if ({1'b0, i_item.data.index} < 5'(w_n) &&
                            i_item.data.action == ACT_READ) begin
                            r_res.param_value <= r_best[IdxW'(i_item.data.index)];
                            r_res.test_value  <= r_trial[IdxW'(i_item.data.index)];
                        end else begin
                            r_res.param_value <= '0;
                            r_res.test_value  <= '0;
                        end
                        if (i_item.data.action != ACT_REPORT &&
                            i_item.data.action != ACT_RESTART) begin
                            r_out_valid <= 1'b1;
                            r_res.best_fitness_out <= r_score;
                            r_res.temperature_out  <= r_temp;
                        end
                    end
                end
                ST_SWEEP: begin
                    // one entry per cycle
                    if (w_n != '0) begin
                        if (r_item.action == ACT_RESTART) begin
                            r_best[r_ptr]  <= '0;
                            r_trial[r_ptr] <= '0;
                            r_lower[r_ptr] <= LimitLow;
                            r_upper[r_ptr] <= LimitHigh;
                        end else if (r_improved) begin
                            r_best[r_ptr] <= r_trial[r_ptr];
                        end else begin
                            r_trial[r_ptr] <= r_best[r_ptr];
                        end
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (n_state == ST_DONE) begin
                        r_score <= 32'sh8000_0000;
                        r_temp  <= TempOne;
                        r_res.best_fitness_out <= 32'sh8000_0000;
                        r_res.temperature_out  <= TempOne;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_PICK: begin
                    if (w_mul[16 +: CntW] >= 66'(w_n)) begin
                        r_k <= IdxW'(w_n - 1'b1);
                    end else begin
                        r_k <= IdxW'(w_mul[16 +: CntW]);
                    end
                end
                ST_FETCH: begin
                    r_lo  <= 34'(r_lower[r_k]);
                    r_hi  <= 34'(r_upper[r_k]);
                    r_cur <= 34'(r_best[r_k]);
                end
                ST_RADIUS_MUL: r_prod <= w_mul;
                ST_ENDS: begin
                    r_lo <= w_lo_c;
                    r_hi <= w_hi_c;
                end
                ST_SPAN_MUL: r_prod <= w_mul;
                ST_WRITE: begin
                    r_trial[r_k] <= 32'(r_lo + w_rad);
                    r_mutated <= 1'b1;
                end
                ST_TEMP_MUL: r_prod <= w_mul;
                ST_TEMP_CLAMP: begin
                    if (w_shr < 50'(w_flo)) begin
                        r_temp <= w_flo;
                        r_res.temperature_out <= w_flo;
                    end else if (w_shr > 50'(TempOne)) begin
                        r_temp <= TempOne;
                        r_res.temperature_out <= TempOne;
                    end else begin
                        r_temp <= 17'(w_shr);
                        r_res.temperature_out <= 17'(w_shr);
                    end
                    r_res.best_fitness_out <= r_score;
                    r_res.improved <= r_improved;
                    r_res.mutated_index <= r_mutated ? 4'(r_k) : 4'd0;
                    r_out_valid <= 1'b1;
                end
                ST_DONE: begin
                    if (o_result.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_hit = r_out_valid;
    assign w_fit_ok = r_res.best_fitness_out;

    // a result waits only in its own state
    `ARPS_ASSERT_IMP(a_valid_done, i_clk, i_rst_n, w_hit, r_state == ST_DONE)
    // temperature never leaves [0, 1.0]
    `ARPS_ASSERT_IMP(a_temp_range, i_clk, i_rst_n, 1'b1, r_temp <= TempOne)
    // an improved result carries the stored best fitness
    `ARPS_ASSERT_IMP(a_improved_score, i_clk, i_rst_n, w_hit && r_res.improved,
        w_fit_ok == r_score)
    // taken result frees the block next cycle
    `ARPS_ASSERT_NXT(a_release, i_clk, i_rst_n, w_hit && o_result.ready,
        r_state == ST_IDLE && !r_out_valid)
endmodule
